### hdl/ps2mct_pkg.sv
`default_nettype none
package ps2mct_pkg;

	// Pointer bitmap size in pixels; the lower right limit of the cursor follows from it.
	localparam int unsigned CURSOR_WIDTH  = 12;
	localparam int unsigned CURSOR_HEIGHT = 20;
	localparam int unsigned CSIZE_W       = 7;

	// Screen geometry after reset.
	localparam int unsigned COORD_W        = 12;
	localparam logic [11:0] RESET_WIDTH    = 12'd1024;
	localparam logic [11:0] RESET_HEIGHT   = 12'd768;

	// Flags byte layout: the sync bit is always set, the low bits are the buttons.
	localparam logic [7:0] FLAGS_SYNC_MASK   = 8'h08;
	localparam logic [7:0] FLAGS_BUTTON_MASK = 8'h07;

	// Register file layout.
	localparam int unsigned PADDR_W = 3;
	typedef enum logic {
		REG_SCREEN_WIDTH  = 1'b0,
		REG_SCREEN_HEIGHT = 1'b1
	} reg_idx_t;

	// Position within a three-byte packet.
	typedef enum logic [1:0] {
		PH_FLAGS = 2'd0,
		PH_DX    = 2'd1,
		PH_DY    = 2'd2
	} phase_t;

	// Screen geometry as seen by the packet logic.
	typedef struct packed {
		logic [11:0] width;
		logic [11:0] height;
		logic        recentre;
	} screen_cfg_t;

endpackage
`default_nettype wire

### hdl/ps2mct_regs.sv
`default_nettype none
module ps2mct_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [ps2mct_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [31:0]                       pwdata,
	output logic      [31:0]                       prdata,
	output logic                                   pready,
	output ps2mct_pkg::screen_cfg_t                cfg
);
	import ps2mct_pkg::*;

	logic [11:0] width_q;
	logic [11:0] height_q;
	logic        wr_en;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes; the low address bits are not decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (wr_en) begin
			case (idx)
				REG_SCREEN_WIDTH:  width_q  <= pwdata[11:0];
				REG_SCREEN_HEIGHT: height_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		case (idx)
			REG_SCREEN_WIDTH:  prdata = {20'd0, width_q};
			REG_SCREEN_HEIGHT: prdata = {20'd0, height_q};
			default:           prdata = 32'd0;
		endcase
	end

	// Any write moves the cursor back to the screen center, using the new value.
	always_comb begin
		cfg.width    = width_q;
		cfg.height   = height_q;
		cfg.recentre = wr_en;
		if (wr_en) begin
			case (idx)
				REG_SCREEN_WIDTH:  cfg.width  = pwdata[11:0];
				REG_SCREEN_HEIGHT: cfg.height = pwdata[11:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/ps2mct_axis.sv
`default_nettype none
module ps2mct_axis (
	input  wire logic [11:0]                      pos,
	input  wire logic signed [8:0]                delta,
	input  wire logic [11:0]                      size,
	input  wire logic [ps2mct_pkg::CSIZE_W-1:0]   cur_size,
	output logic      [11:0]                      pos_next
);
	import ps2mct_pkg::*;

	logic signed [13:0] sum;
	logic signed [13:0] hi;
	logic signed [13:0] lim;
	logic signed [13:0] clamped;

	// Move, then clamp to 0 .. screen size minus cursor size (never below 0).
	always_comb begin
		sum = $signed({2'b00, pos}) + $signed({{5{delta[8]}}, delta});
		hi  = $signed({2'b00, size}) - $signed({{(14-CSIZE_W){1'b0}}, cur_size});
		lim = (hi < 0) ? 14'sd0 : hi;
		if (sum < 0) begin
			clamped = 14'sd0;
		end else if (sum > lim) begin
			clamped = lim;
		end else begin
			clamped = sum;
		end
		pos_next = clamped[11:0];
	end

endmodule
`default_nettype wire

### hdl/ps2mct_packet.sv
`default_nettype none
module ps2mct_packet (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step,
	input  wire logic [7:0]                data,
	input  wire ps2mct_pkg::screen_cfg_t   cfg,
	input  wire logic                      pkt_stall,
	output logic                           pkt_valid,
	output logic                           busy,
	output logic [2:0]                     buttons,
	output logic [11:0]                    pos_x,
	output logic [11:0]                    pos_y,
	output logic                           moved
);
	import ps2mct_pkg::*;

	phase_t      phase_q;
	logic [7:0]  flags_q;
	logic [7:0]  dx_q;
	logic        discard_q;
	logic [11:0] cur_x_q;
	logic [11:0] cur_y_q;
	logic        valid_q;

	logic              pkt_done;
	logic              emit;
	logic signed [8:0] dx;
	logic signed [8:0] ndy;
	logic              mv;
	logic [11:0]       nx;
	logic [11:0]       ny;

	// A packet completes on the third byte; the first one after reset is dropped.
	assign pkt_done = step && (phase_q == PH_DY);
	assign emit     = pkt_done && !discard_q;
	assign dx       = $signed({dx_q[7], dx_q});
	assign ndy      = 9'sd0 - $signed({data[7], data});
	assign mv       = (dx_q != 8'd0) || (data != 8'd0);
	assign busy     = valid_q && pkt_stall;

	ps2mct_axis u_axis_x (
		.pos      (cur_x_q),
		.delta    (dx),
		.size     (cfg.width),
		.cur_size (CSIZE_W'(CURSOR_WIDTH)),
		.pos_next (nx)
	);

	ps2mct_axis u_axis_y (
		.pos      (cur_y_q),
		.delta    (ndy),
		.size     (cfg.height),
		.cur_size (CSIZE_W'(CURSOR_HEIGHT)),
		.pos_next (ny)
	);

	// Byte phase, held bytes and cursor position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FLAGS;
			flags_q   <= 8'd0;
			dx_q      <= 8'd0;
			discard_q <= 1'b1;
			cur_x_q   <= RESET_WIDTH >> 1;
			cur_y_q   <= RESET_HEIGHT >> 1;
		end else begin
			if (cfg.recentre) begin
				cur_x_q <= cfg.width >> 1;
				cur_y_q <= cfg.height >> 1;
			end else if (emit && mv) begin
				cur_x_q <= nx;
				cur_y_q <= ny;
			end
			if (step) begin
				case (phase_q)
					PH_DX: begin
						dx_q    <= data;
						phase_q <= PH_DY;
					end
					PH_DY: begin
						phase_q   <= PH_FLAGS;
						discard_q <= 1'b0;
					end
					default: begin
						if ((data & FLAGS_SYNC_MASK) != 8'd0) begin
							flags_q <= data;
							phase_q <= PH_DX;
						end else begin
							phase_q <= PH_FLAGS;
						end
					end
				endcase
			end
		end
	end

	// Result register: loaded when a packet reports, emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (!pkt_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			buttons <= flags_q[2:0] & FLAGS_BUTTON_MASK[2:0];
			pos_x   <= mv ? nx : cur_x_q;
			pos_y   <= mv ? ny : cur_y_q;
			moved   <= mv;
		end
	end

	assign pkt_valid = valid_q;

endmodule
`default_nettype wire

### hdl/ps2_mouse_packet_cursor_tracker.sv
`default_nettype none
// A result is registered in the result register once the third byte of its packet steps out of the input byte register.
// Throughput: one byte per cycle; the byte stage holds only while a result waits under stall.
// Each byte takes one pass through the packet logic between the input and result registers.
// Reset: screen 1024x768, cursor centered, waiting for a flags byte, first packet dropped.
// A screen register write re-centers the cursor in the same cycle.
module ps2_mouse_packet_cursor_tracker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ps2mct_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                     pwdata,
	output logic      [31:0]                     prdata,
	output logic                                 pready,
	input  wire logic                            byte_valid,
	output logic                                 byte_stall,
	input  wire logic [7:0]                      data_byte,
	output logic                                 pkt_valid,
	input  wire logic                            pkt_stall,
	output logic [2:0]                           buttons,
	output logic [11:0]                          pos_x,
	output logic [11:0]                          pos_y,
	output logic                                 moved
);
	import ps2mct_pkg::*;

	screen_cfg_t cfg;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        busy;
	logic        step;

	ps2mct_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input byte register; it holds while the result register cannot take a packet.
	assign byte_stall = valid_s1 && busy;
	assign step       = valid_s1 && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			data_s1 <= data_byte;
		end
	end

	ps2mct_packet u_packet (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data      (data_s1),
		.cfg       (cfg),
		.pkt_stall (pkt_stall),
		.pkt_valid (pkt_valid),
		.busy      (busy),
		.buttons   (buttons),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.moved     (moved)
	);

endmodule
`default_nettype wire
